### hdl/pqpa_pkg.sv
package pqpa_pkg;

	// Fixed field widths
	localparam int OPCODE_W = 2;
	localparam int PRIO_W   = 8;
	localparam int SIDX_W   = 5;
	localparam int STATUS_W = 3;
	localparam int ID_W     = 16;
	localparam int POOL_W   = 2;
	localparam int WCNT_W   = 6;
	localparam int CFG_W    = 6;
	localparam int CFG_IDX_W = 2;

	// Default sizes
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int SLOT_COUNT_DEF  = 32;

	// Register reset values
	localparam logic [CFG_W-1:0] POOL_B_FIRST_RST = CFG_W'(4);
	localparam logic [CFG_W-1:0] POOL_C_FIRST_RST = CFG_W'(8);
	localparam logic [CFG_W-1:0] SLOT_LIMIT_RST   = CFG_W'(20);
	localparam logic [ID_W-1:0]  REQ_ID_RST       = ID_W'(1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_B_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_C_FIRST = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd2;

	// Opcodes
	localparam logic [OPCODE_W-1:0] OP_ENQUEUE  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DISPATCH = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RELEASE  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_NOP      = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY = 3'd2;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SLOT_RANGE  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SLOT_FREE   = 3'd5;

	// Pools
	localparam logic [POOL_W-1:0] POOL_A = 2'd0;
	localparam logic [POOL_W-1:0] POOL_B = 2'd1;
	localparam logic [POOL_W-1:0] POOL_C = 2'd2;

	localparam logic [PRIO_W-1:0] PRIO_POOL_A = PRIO_W'(1);
	localparam logic [PRIO_W-1:0] PRIO_POOL_B = PRIO_W'(2);

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [ID_W-1:0]   id;
	} qentry_t;

	typedef struct packed {
		logic enq;
		logic pop;
	} qctl_t;

	typedef struct packed {
		logic              found;
		logic [SIDX_W-1:0] slot;
		logic [POOL_W-1:0] pool;
		logic              out_of_range;
		logic              already_free;
	} alloc_status_t;

endpackage

### hdl/pqpa_req_if.sv
interface pqpa_req_if
	import pqpa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [PRIO_W-1:0]   request_priority;
	logic [SIDX_W-1:0]   slot_index;

	modport source (output valid, opcode, request_priority, slot_index, input ready);
	modport sink (input valid, opcode, request_priority, slot_index, output ready);
endinterface

### hdl/pqpa_rsp_if.sv
interface pqpa_rsp_if
	import pqpa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     request_id;
	logic [PRIO_W-1:0]   served_priority;
	logic [SIDX_W-1:0]   granted_slot;
	logic [POOL_W-1:0]   pool_granted;
	logic [WCNT_W-1:0]   waiting_count;

	modport source (output valid, status, request_id, served_priority, granted_slot,
		pool_granted, waiting_count, input ready);
	modport sink (input valid, status, request_id, served_priority, granted_slot,
		pool_granted, waiting_count, output ready);
endinterface

### hdl/priority_queue_pool_allocator_core.sv
// Priority queue with a three-pool slot allocator. Each request on req carries
// an opcode: enqueue gives the priority the next 16-bit id and inserts it into
// a stable sorted queue (lower value first, ties in arrival order); dispatch
// grants the head request the lowest free slot of its pool (priority 1 pool A,
// 2 pool B, anything else the general pool C) and pops it, or answers pool
// full and leaves it queued; release frees a slot; opcode 3 does nothing.
// Every request yields exactly one response on rsp. A request is taken in
// every cycle in which the response register is empty or being drained, so
// the block sustains one request per clock; the registered response appears
// in the cycle after acceptance. Queue cell compares and the slot priority
// encoder are combinational. The pool bounds must be written on the cfg port
// only while no request is in flight; the block does not enforce it. Each
// bound is clamped to SLOT_COUNT. No clearing pass is needed after reset.
module priority_queue_pool_allocator_core
	import pqpa_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	pqpa_req_if.sink             req,
	pqpa_rsp_if.source           rsp
);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	// configuration
	logic [CFG_W-1:0] pool_b_first_q;
	logic [CFG_W-1:0] pool_c_first_q;
	logic [CFG_W-1:0] slot_limit_q;

	// queue bookkeeping
	logic [CNTW-1:0] count_q;
	logic [CNTW-1:0] count_next;
	logic [ID_W-1:0] next_id_q;

	// response register
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     request_id_q;
	logic [PRIO_W-1:0]   served_prio_q;
	logic [SIDX_W-1:0]   granted_slot_q;
	logic [POOL_W-1:0]   pool_granted_q;
	logic [WCNT_W-1:0]   waiting_count_q;

	logic                req_acc;
	logic                q_full;
	logic                q_empty;
	qctl_t               qctl;
	qentry_t             new_entry;
	qentry_t             cell_entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_valid;
	logic [QUEUE_DEPTH-1:0] cell_bigger;
	alloc_status_t       astat;
	logic                alloc_en;
	logic                release_en;
	logic                sorted_ok;

	logic [STATUS_W-1:0] r_status;
	logic [ID_W-1:0]     r_id;
	logic [PRIO_W-1:0]   r_prio;
	logic [SIDX_W-1:0]   r_slot;
	logic [POOL_W-1:0]   r_pool;

	// the response register frees as soon as it drains
	assign req.ready = !out_valid_q || rsp.ready;
	assign req_acc   = req.valid && req.ready;

	assign q_full  = (count_q == CNTW'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);

	assign new_entry.prio = req.request_priority;
	assign new_entry.id   = next_id_q;

	assign qctl.enq   = req_acc && (req.opcode == OP_ENQUEUE) && !q_full;
	assign alloc_en   = req_acc && (req.opcode == OP_DISPATCH) && !q_empty;
	assign qctl.pop   = alloc_en && astat.found;
	assign release_en = req_acc && (req.opcode == OP_RELEASE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_b_first_q <= POOL_B_FIRST_RST;
			pool_c_first_q <= POOL_C_FIRST_RST;
			slot_limit_q   <= SLOT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_POOL_B_FIRST: pool_b_first_q <= cfg_data;
				CFG_POOL_C_FIRST: pool_c_first_q <= cfg_data;
				CFG_SLOT_LIMIT:   slot_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sorted queue: a row of cells, head at cell 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		qentry_t l_entry;
		logic    l_valid;
		logic    l_bigger;
		qentry_t r_entry;
		logic    r_valid;

		if (i == 0) begin : g_head
			assign l_entry  = new_entry;
			assign l_valid  = 1'b1;
			assign l_bigger = 1'b0;
		end else begin : g_mid
			assign l_entry  = cell_entry[i-1];
			assign l_valid  = cell_valid[i-1];
			assign l_bigger = cell_bigger[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_entry = cell_entry[i];
			assign r_valid = 1'b0;
		end else begin : g_inner
			assign r_entry = cell_entry[i+1];
			assign r_valid = cell_valid[i+1];
		end

		pqpa_qcell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (qctl),
			.new_entry   (new_entry),
			.left_entry  (l_entry),
			.left_valid  (l_valid),
			.left_bigger (l_bigger),
			.right_entry (r_entry),
			.right_valid (r_valid),
			.entry       (cell_entry[i]),
			.valid       (cell_valid[i]),
			.bigger      (cell_bigger[i])
		);
	end

	// slot flags; the owner id a slot holds is never reported, so it is not kept
	pqpa_slot_alloc #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_alloc (
		.clk          (clk),
		.arst_n       (arst_n),
		.pool_b_first (pool_b_first_q),
		.pool_c_first (pool_c_first_q),
		.slot_limit   (slot_limit_q),
		.head_prio    (cell_entry[0].prio),
		.alloc_en     (alloc_en),
		.release_idx  (req.slot_index),
		.release_en   (release_en),
		.stat         (astat)
	);

	// response for the request at the port
	always_comb begin
		r_status   = ST_OK;
		r_id       = '0;
		r_prio     = '0;
		r_slot     = '0;
		r_pool     = '0;
		count_next = count_q;
		case (req.opcode)
			OP_ENQUEUE: begin
				if (q_full) begin
					r_status = ST_QUEUE_FULL;
				end else begin
					r_id       = next_id_q;
					count_next = count_q + 1'b1;
				end
			end
			OP_DISPATCH: begin
				if (q_empty) begin
					r_status = ST_QUEUE_EMPTY;
				end else begin
					r_id   = cell_entry[0].id;
					r_prio = cell_entry[0].prio;
					r_pool = astat.pool;
					if (astat.found) begin
						r_slot     = astat.slot;
						count_next = count_q - 1'b1;
					end else begin
						r_status = ST_POOL_FULL;
					end
				end
			end
			OP_RELEASE: begin
				if (astat.out_of_range) begin
					r_status = ST_SLOT_RANGE;
				end else if (astat.already_free) begin
					r_status = ST_SLOT_FREE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			next_id_q   <= REQ_ID_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (req_acc) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (qctl.enq) begin
				next_id_q <= next_id_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			status_q        <= r_status;
			request_id_q    <= r_id;
			served_prio_q   <= r_prio;
			granted_slot_q  <= r_slot;
			pool_granted_q  <= r_pool;
			waiting_count_q <= WCNT_W'(count_next);
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = status_q;
	assign rsp.request_id      = request_id_q;
	assign rsp.served_priority = served_prio_q;
	assign rsp.granted_slot    = granted_slot_q;
	assign rsp.pool_granted    = pool_granted_q;
	assign rsp.waiting_count   = waiting_count_q;

	// adjacent occupied cells must be in nondecreasing priority order
	always_comb begin
		sorted_ok = 1'b1;
		for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
			if (cell_valid[i+1] && (!cell_valid[i]
				|| (cell_entry[i].prio > cell_entry[i+1].prio))) begin
				sorted_ok = 1'b0;
			end
		end
	end

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == count_q)
		else $error("queue count disagrees with occupied cells");

	a_queue_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		sorted_ok)
		else $error("queue cells out of order or not contiguous");

	a_enqueue_grows: assert property (@(posedge clk) disable iff (!arst_n)
		qctl.enq |=> (count_q == $past(count_q) + 1'b1))
		else $error("enqueue did not grow the queue by one");
endmodule

### hdl/pqpa_qcell.sv
// One queue position. Entries stay sorted along the row; on insert each cell
// either keeps its entry, takes the new one, or takes its left neighbor's.
module pqpa_qcell
	import pqpa_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  qctl_t   ctl,
	input  qentry_t new_entry,
	input  qentry_t left_entry,
	input  logic    left_valid,
	input  logic    left_bigger,
	input  qentry_t right_entry,
	input  logic    right_valid,
	output qentry_t entry,
	output logic    valid,
	output logic    bigger
);
	qentry_t entry_q;
	logic    valid_q;

	// strictly greater keeps equal priorities in arrival order
	assign bigger = !valid_q || (entry_q.prio > new_entry.prio);
	assign entry  = entry_q;
	assign valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.enq) begin
			valid_q <= valid_q | left_valid;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (left_bigger) begin
				entry_q <= left_entry;
			end else if (bigger) begin
				entry_q <= new_entry;
			end
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end
endmodule

### hdl/pqpa_slot_alloc.sv
// Slot free flags with range mask and lowest-free-slot priority encoder.
module pqpa_slot_alloc
	import pqpa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CFG_W-1:0]   pool_b_first,
	input  logic [CFG_W-1:0]   pool_c_first,
	input  logic [CFG_W-1:0]   slot_limit,
	input  logic [PRIO_W-1:0]  head_prio,
	input  logic               alloc_en,
	input  logic [SIDX_W-1:0]  release_idx,
	input  logic               release_en,
	output alloc_status_t      stat
);
	localparam int SIW = $clog2(SLOT_COUNT);
	localparam int SW1 = $clog2(SLOT_COUNT + 1);
	localparam int EW  = (SW1 > CFG_W) ? SW1 : CFG_W;

	logic [SLOT_COUNT-1:0] free_q;
	logic [SLOT_COUNT-1:0] range_mask;
	logic [SLOT_COUNT-1:0] cand;
	logic [SLOT_COUNT-1:0] first_hot;
	logic [SIW-1:0]        first_idx;
	logic [EW-1:0]         lo;
	logic [EW-1:0]         hi;
	logic [EW-1:0]         limit_c;
	logic                  idx_free;

	function automatic logic [EW-1:0] clamp_slot(input logic [CFG_W-1:0] v);
		logic [EW-1:0] ve;
		ve = EW'(v);
		return (ve > EW'(SLOT_COUNT)) ? EW'(SLOT_COUNT) : ve;
	endfunction

	always_comb begin
		limit_c = clamp_slot(slot_limit);
		if (head_prio == PRIO_POOL_A) begin
			stat.pool = POOL_A;
			lo        = '0;
			hi        = clamp_slot(pool_b_first);
		end else if (head_prio == PRIO_POOL_B) begin
			stat.pool = POOL_B;
			lo        = clamp_slot(pool_b_first);
			hi        = clamp_slot(pool_c_first);
		end else begin
			stat.pool = POOL_C;
			lo        = clamp_slot(pool_c_first);
			hi        = limit_c;
		end
		for (int i = 0; i < SLOT_COUNT; i++) begin
			range_mask[i] = (EW'(i) >= lo) && (EW'(i) < hi);
		end
		cand      = range_mask & free_q;
		first_hot = cand & (~cand + SLOT_COUNT'(1));
		first_idx = '0;
		idx_free  = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (first_hot[i]) begin
				first_idx = first_idx | SIW'(i);
			end
			if (EW'(i) == EW'(release_idx)) begin
				idx_free = idx_free | free_q[i];
			end
		end
		stat.found        = |cand;
		stat.slot         = SIDX_W'(first_idx);
		stat.out_of_range = EW'(release_idx) >= limit_c;
		stat.already_free = idx_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (alloc_en && first_hot[i]) begin
					free_q[i] <= 1'b0;
				end else if (release_en && !stat.out_of_range
					&& (EW'(i) == EW'(release_idx))) begin
					free_q[i] <= 1'b1;
				end
			end
		end
	end

	a_grant_takes_one: assert property (@(posedge clk) disable iff (!arst_n)
		(alloc_en && stat.found) |=> ($countones(free_q) == $past($countones(free_q)) - 1))
		else $error("grant did not take exactly one slot");
endmodule

### tb/sv/pqpa_alloc_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register ports of the queue/allocator,
// predicts every response and compares it against what the block returns.
module pqpa_alloc_checker
	import pqpa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	pqpa_req_if                  req,
	pqpa_rsp_if                  rsp,
	output int                   outstanding,
	output int                   fail_count
);

	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int SLOTS  = SLOT_COUNT_DEF;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     request_id;
		logic [PRIO_W-1:0]   served_priority;
		logic [SIDX_W-1:0]   granted_slot;
		logic [POOL_W-1:0]   pool_granted;
		logic [WCNT_W-1:0]   waiting_count;
	} outcome_t;

	// predictor state
	logic [PRIO_W-1:0] order_prio [QDEPTH];
	logic [ID_W-1:0]   order_id [QDEPTH];
	int                order_len;
	bit [SLOTS-1:0]    slot_idle;
	logic [ID_W-1:0]   id_counter;
	logic [CFG_W-1:0]  b_start;
	logic [CFG_W-1:0]  c_start;
	logic [CFG_W-1:0]  slot_end;

	outcome_t predicted_responses [$];

	function automatic int bound_of(input logic [CFG_W-1:0] v);
		return (int'(v) > SLOTS) ? SLOTS : int'(v);
	endfunction

	function automatic outcome_t serve_request(input logic [OPCODE_W-1:0] op,
		input logic [PRIO_W-1:0] prio, input logic [SIDX_W-1:0] sidx);
		outcome_t o;
		int pos;
		int lo;
		int hi;
		int found;
		int i;
		o = '0;
		case (op)
		OP_ENQUEUE: begin
			if (order_len >= QDEPTH) begin
				o.status = ST_QUEUE_FULL;
			end else begin
				o.request_id = id_counter;
				pos = order_len;
				// stable insert: only strictly larger priorities move back
				while (pos > 0 && order_prio[pos-1] > prio) begin
					order_prio[pos] = order_prio[pos-1];
					order_id[pos] = order_id[pos-1];
					pos--;
				end
				order_prio[pos] = prio;
				order_id[pos] = id_counter;
				id_counter = id_counter + 1'b1;
				order_len++;
			end
		end
		OP_DISPATCH: begin
			if (order_len == 0) begin
				o.status = ST_QUEUE_EMPTY;
			end else begin
				o.request_id = order_id[0];
				o.served_priority = order_prio[0];
				if (order_prio[0] == PRIO_POOL_A) begin
					o.pool_granted = POOL_A;
					lo = 0;
					hi = bound_of(b_start);
				end else if (order_prio[0] == PRIO_POOL_B) begin
					o.pool_granted = POOL_B;
					lo = bound_of(b_start);
					hi = bound_of(c_start);
				end else begin
					o.pool_granted = POOL_C;
					lo = bound_of(c_start);
					hi = bound_of(slot_end);
				end
				found = -1;
				for (i = lo; i < hi; i++)
					if (found < 0 && slot_idle[i])
						found = i;
				if (found < 0) begin
					o.status = ST_POOL_FULL;
				end else begin
					slot_idle[found] = 1'b0;
					o.granted_slot = SIDX_W'(found);
					for (i = 0; i + 1 < order_len; i++) begin
						order_prio[i] = order_prio[i+1];
						order_id[i] = order_id[i+1];
					end
					order_len--;
				end
			end
		end
		OP_RELEASE: begin
			if (int'(sidx) >= bound_of(slot_end))
				o.status = ST_SLOT_RANGE;
			else if (slot_idle[sidx])
				o.status = ST_SLOT_FREE;
			else
				slot_idle[sidx] = 1'b1;
		end
		default: ;
		endcase
		o.waiting_count = WCNT_W'(order_len);
		return o;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			order_len = 0;
			slot_idle = '1;
			id_counter = REQ_ID_RST;
			b_start = POOL_B_FIRST_RST;
			c_start = POOL_C_FIRST_RST;
			slot_end = SLOT_LIMIT_RST;
			predicted_responses.delete();
			fail_count = 0;
		end else begin
			// responses first: a response at this edge belongs to an older request
			if (rsp.valid && rsp.ready) begin
				if (predicted_responses.size() == 0) begin
					$display("%0t: response with no request pending, status %0d id %0d",
						$time, rsp.status, rsp.request_id);
					fail_count++;
				end else begin
					want = predicted_responses.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("request_id", want.request_id, rsp.request_id);
					check_field("served_priority", want.served_priority,
						rsp.served_priority);
					check_field("granted_slot", want.granted_slot, rsp.granted_slot);
					check_field("pool_granted", want.pool_granted, rsp.pool_granted);
					check_field("waiting_count", want.waiting_count, rsp.waiting_count);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_POOL_B_FIRST: b_start = cfg_data;
				CFG_POOL_C_FIRST: c_start = cfg_data;
				CFG_SLOT_LIMIT:   slot_end = cfg_data;
				default: ;
				endcase
			end
			if (req.valid && req.ready)
				predicted_responses.push_back(serve_request(req.opcode,
					req.request_priority, req.slot_index));
		end
		outstanding = predicted_responses.size();
	end

endmodule

### tb/sv/tb_priority_queue_pool_allocator_core.sv
`timescale 1ns / 100ps

module tb_priority_queue_pool_allocator_core;
	import pqpa_pkg::*;

	// Generous cycle budget for about 400 requests, even with both sides stalling.
	localparam int CYCLE_LIMIT = 50000;
	// Enqueue/dispatch/release rounds in the stretch with no idling.
	localparam int CALM_ROUNDS = 8;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int outstanding;
	int fail_count;
	int cycle_count = 0;
	int slot_end_now = 20;   // clamped slot limit, steers release indexes
	bit calm = 1'b0;         // set: neither side idles

	pqpa_req_if req_ch ();
	pqpa_rsp_if rsp_ch ();

	priority_queue_pool_allocator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	pqpa_alloc_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always #1 clk = ~clk;

	// Hard stop if the block hangs or drops responses.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Response side: stalls ~32% of cycles unless calm.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= arst_n && (calm || $urandom_range(99) >= 32);
		end
	end

	// Present one request and hold it until accepted. Optional idle cycles
	// go first, so valid is never dropped and raised in the same step.
	task automatic push_request(input logic [OPCODE_W-1:0] op,
		input logic [PRIO_W-1:0] prio, input logic [SIDX_W-1:0] sidx);
		while (!calm && $urandom_range(99) < 32) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.request_priority <= prio;
		req_ch.slot_index <= sidx;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// Quiesce: stop requests and wait until every response is back.
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (3) @(posedge clk);
	endtask

	// Back-to-back writes of all three bounds; only call while idle.
	task automatic load_bounds(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] c,
		input logic [CFG_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= CFG_POOL_B_FIRST;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= CFG_POOL_C_FIRST;
		cfg_data <= c;
		@(posedge clk);
		cfg_index <= CFG_SLOT_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_end_now = (int'(lim) > SLOT_COUNT_DEF) ? SLOT_COUNT_DEF : int'(lim);
	endtask

	// One pool layout, then a random mix. Priorities lean on 1 and 2 so the
	// small pools fill up; releases mostly target slots inside the limit.
	task automatic run_phase(input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] c,
		input logic [CFG_W-1:0] lim, input int n);
		int i;
		int pick;
		logic [OPCODE_W-1:0] op;
		logic [PRIO_W-1:0]   prio;
		logic [SIDX_W-1:0]   sidx;
		settle();
		load_bounds(b, c, lim);
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				op = OP_ENQUEUE;
			else if (pick < 72)
				op = OP_DISPATCH;
			else if (pick < 95)
				op = OP_RELEASE;
			else
				op = OP_NOP;
			pick = $urandom_range(99);
			if (pick < 30)
				prio = PRIO_POOL_A;
			else if (pick < 60)
				prio = PRIO_POOL_B;
			else if (pick < 70)
				prio = '0;
			else if (pick < 78)
				prio = '1;
			else
				prio = PRIO_W'($urandom_range(255));
			if (slot_end_now > 0 && $urandom_range(3) != 0)
				sidx = SIDX_W'($urandom_range(slot_end_now - 1));
			else
				sidx = SIDX_W'($urandom_range(31));
			push_request(op, prio, sidx);
		end
	endtask

	initial begin
		int k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_POOL_B_FIRST;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_NOP;
		req_ch.request_priority <= '0;
		req_ch.slot_index <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset layout A [0,4), B [4,8), C [8,20).
		push_request(OP_DISPATCH, '0, '0);           // empty queue
		push_request(OP_RELEASE, '0, 5'd31);         // beyond slot limit
		push_request(OP_RELEASE, '0, '0);            // slot never taken
		push_request(OP_NOP, '1, '1);
		// ties on 1 and 2 must keep arrival order
		push_request(OP_ENQUEUE, '1, '0);
		push_request(OP_ENQUEUE, '0, '0);
		push_request(OP_ENQUEUE, PRIO_POOL_A, '0);
		push_request(OP_ENQUEUE, PRIO_POOL_B, '0);
		push_request(OP_ENQUEUE, PRIO_POOL_B, '0);
		push_request(OP_ENQUEUE, PRIO_POOL_A, '0);
		for (k = 0; k < 6; k++)
			push_request(OP_DISPATCH, '0, '0);      // drains through all pools
		push_request(OP_RELEASE, '0, '0);            // held, frees
		push_request(OP_RELEASE, '0, '0);            // now already free
		push_request(OP_RELEASE, '0, 5'd19);         // last slot in range
		push_request(OP_RELEASE, '0, 5'd20);         // first slot out of range

		// Long stretch with no idling on either side: free every slot, then
		// enqueue/dispatch/release cycles through one general slot.
		settle();
		calm = 1'b1;
		load_bounds(6'd4, 6'd8, 6'd32);
		for (k = 0; k < 32; k++)
			push_request(OP_RELEASE, '0, SIDX_W'(k));
		for (k = 0; k < CALM_ROUNDS; k++) begin
			push_request(OP_ENQUEUE, '0, '0);
			push_request(OP_DISPATCH, '0, '0);
			push_request(OP_RELEASE, '0, 5'd8);
		end
		settle();
		calm = 1'b0;

		// Random phases across pool layouts, extremes included:
		// all pools empty, one pool owning everything, inverted and clamped
		// bounds, tiny pools that fill the queue through pool-full stalls.
		run_phase(6'd4, 6'd8, 6'd20, 60);
		run_phase(6'd0, 6'd0, 6'd0, 40);
		run_phase(6'd32, 6'd32, 6'd32, 50);
		run_phase(6'd2, 6'd3, 6'd6, 60);
		run_phase(6'd63, 6'd20, 6'd63, 50);
		run_phase(6'd1, 6'd16, 6'd32, 60);

		settle();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
